>>> hw/rtl/bbd_pkg.sv
package bbd_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int SAMPLE_BITS = 12;

  localparam int CFG_BITS     = 13;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = CFG_BITS'(480);

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int DIM_A = (WID_W > HGT_W) ? WID_W : HGT_W;
  localparam int DIM_W = (DIM_A > CFG_BITS) ? DIM_A : CFG_BITS;
  localparam int PEND_W = DIM_W + 1;

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic                    write;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0]     data;
  } cfg_wr_t;

  // px[row][col]: row 0 above, 1 center, 2 below; col 0 left, 1 center, 2 right
  typedef struct packed {
    sample_t [2:0][2:0] px;
    logic               up;
    logic               down;
    logic               left;
    logic               right;
    logic               row_odd;
    logic               col_odd;
    logic               row_end;
    logic               frame_end;
  } win_cmd_t;

  typedef enum logic [1:0] {
    FS_WAIT,
    FS_LOAD,
    FS_RUN
  } front_state_t;

  typedef enum logic [1:0] {
    SITE_GR   = 2'b00,
    SITE_RED  = 2'b01,
    SITE_BLUE = 2'b10,
    SITE_GB   = 2'b11
  } site_t;

endpackage

>>> hw/rtl/bayer_bilinear_demosaic.sv
// Each window word passes through the command queue, stage s1 and the output registers;
// results trail input samples by one row plus one pixel.
// Throughput: one word per cycle along a row while the window queue is not full; each output
// row first loads its window from the line store in state FS_LOAD, while full is held high.
// Reset (rst, synchronous): positions, counts and queues clear, frame size goes to 640x480;
// the line store is not cleared and needs no clearing pass.
module bayer_bilinear_demosaic import bbd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    push,
  input  logic                    action,
  input  logic [SAMPLE_BITS-1:0]  sample,
  output logic                    full,
  input  logic                    pop,
  output logic                    empty,
  output logic [SAMPLE_BITS-1:0]  red,
  output logic [SAMPLE_BITS-1:0]  green,
  output logic [SAMPLE_BITS-1:0]  blue,
  output logic                    row_end,
  output logic                    frame_end
);

  cfg_wr_t  cfg;
  win_cmd_t cmd_in;
  win_cmd_t cmd_out;
  logic     cmd_push;
  logic     cmd_full;
  logic     cmd_pop;
  logic     cmd_empty;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  bbd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .action   (action),
    .sample   (sample),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  bbd_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  bbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("window word pushed into a full queue");

  a_cmd_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("window word popped from an empty queue");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_end) |-> row_end)
    else $error("frame end without row end");

endmodule

>>> hw/rtl/bbd_front.sv
module bbd_front import bbd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_wr_t  cfg,
  input  logic     push,
  input  logic     action,
  input  sample_t  sample,
  output logic     full,
  output logic     cmd_push,
  output win_cmd_t cmd,
  input  logic     cmd_full
);

  logic [CFG_BITS-1:0] frame_width;
  logic [CFG_BITS-1:0] frame_height;
  logic [COL_W-1:0]    in_col;
  logic [COL_W-1:0]    out_col;
  logic [ROW_W-1:0]    in_row;
  logic [ROW_W-1:0]    out_row;
  logic [SLOT_W-1:0]   in_slot;
  logic [SLOT_W-1:0]   out_slot;
  logic [PEND_W-1:0]   pending;
  logic [PEND_W-1:0]   pending_next;
  front_state_t        state;
  front_state_t        state_next;

  // one lane per row slot
  sample_t [NUM_SLOTS-1:0] mem [MAX_WIDTH];
  sample_t [NUM_SLOTS-1:0] rd_data;
  logic [COL_W-1:0]        rd_addr;

  sample_t [2:0] col_a;
  sample_t [2:0] col_b;
  sample_t [2:0] rd_col;
  sample_t [2:0] new_col;

  logic [DIM_W-1:0]  fw_ext;
  logic [DIM_W-1:0]  fh_ext;
  logic [DIM_W-1:0]  w;
  logic [DIM_W-1:0]  h;
  logic [DIM_W-1:0]  in_col_inc;
  logic [DIM_W-1:0]  in_row_inc;
  logic [DIM_W-1:0]  out_col_inc;
  logic [DIM_W-1:0]  out_row_inc;
  logic [PEND_W-1:0] w_plus1;
  logic [SLOT_W-1:0] slot_u;
  logic [SLOT_W-1:0] slot_d;
  logic              in_col_wrap;
  logic              in_row_wrap;
  logic              out_col_wrap;
  logic              out_row_wrap;
  logic              frame_start;
  logic              pend_full;
  logic              tail;
  logic              fill_ok;
  logic              accept;
  logic              is_flush;
  logic              emit;

  assign fw_ext = DIM_W'(frame_width);
  assign fh_ext = DIM_W'(frame_height);
  assign w = (fw_ext < DIM_W'(2)) ? DIM_W'(2) :
             (fw_ext > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fw_ext;
  assign h = (fh_ext < DIM_W'(2)) ? DIM_W'(2) :
             (fh_ext > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : fh_ext;

  assign in_col_inc   = DIM_W'(in_col) + DIM_W'(1);
  assign in_row_inc   = DIM_W'(in_row) + DIM_W'(1);
  assign out_col_inc  = DIM_W'(out_col) + DIM_W'(1);
  assign out_row_inc  = DIM_W'(out_row) + DIM_W'(1);
  assign in_col_wrap  = in_col_inc >= w;
  assign in_row_wrap  = in_row_inc >= h;
  assign out_col_wrap = out_col_inc >= w;
  assign out_row_wrap = out_row_inc >= h;

  assign w_plus1     = PEND_W'(w) + PEND_W'(1);
  assign frame_start = (in_row == '0) && (in_col == '0);
  assign pend_full   = pending >= w_plus1;
  assign tail        = frame_start && (pending != '0);
  assign fill_ok     = pend_full || tail;

  assign accept   = push && !full;
  assign is_flush = action == ACT_FLUSH;
  assign emit     = accept && (state == FS_RUN) && (is_flush ? tail : pend_full);

  assign slot_u    = out_slot - SLOT_W'(1);
  assign slot_d    = out_slot + SLOT_W'(1);
  assign rd_col[0] = rd_data[slot_u];
  assign rd_col[1] = rd_data[out_slot];
  assign rd_col[2] = rd_data[slot_d];

  // lower row's right column is the word being written now
  always_comb begin
    new_col    = rd_col;
    if (!is_flush) begin
      new_col[2] = sample;
    end
  end

  always_comb begin
    state_next = state;
    full       = cmd_full;
    rd_addr    = '0;
    case (state)
      FS_WAIT: begin
        full = fill_ok;
        if (fill_ok) begin
          state_next = FS_LOAD;
        end
      end
      FS_LOAD: begin
        full       = 1'b1;
        rd_addr    = COL_W'(1);
        state_next = FS_RUN;
      end
      FS_RUN: begin
        full    = cmd_full;
        rd_addr = emit ? COL_W'(out_col_inc + DIM_W'(1)) : COL_W'(out_col_inc);
        if (emit && out_col_wrap) begin
          state_next = FS_WAIT;
        end
      end
      default: begin
        state_next = FS_WAIT;
      end
    endcase
  end

  always_comb begin
    pending_next = pending;
    if (accept) begin
      if (!is_flush) begin
        pending_next = pending + PEND_W'(1) - PEND_W'(emit);
      end else if (emit) begin
        pending_next = pending - PEND_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_flush) begin
      mem[in_col][in_slot] <= sample;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == FS_LOAD) begin
      col_b <= rd_col;
    end else if (emit) begin
      col_a <= col_b;
      col_b <= new_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      in_col       <= '0;
      in_row       <= '0;
      in_slot      <= '0;
      out_col      <= '0;
      out_row      <= '0;
      out_slot     <= '0;
      pending      <= '0;
      state        <= FS_WAIT;
    end else begin
      if (cfg.write) begin
        case (cfg.index)
          CFG_FRAME_WIDTH:  frame_width  <= cfg.data;
          CFG_FRAME_HEIGHT: frame_height <= cfg.data;
          default: ;
        endcase
      end
      state   <= state_next;
      pending <= pending_next;
      if (accept && !is_flush) begin
        if (in_col_wrap) begin
          in_col  <= '0;
          in_slot <= in_slot + SLOT_W'(1);
          in_row  <= in_row_wrap ? '0 : ROW_W'(in_row_inc);
        end else begin
          in_col <= COL_W'(in_col_inc);
        end
      end
      if (emit) begin
        if (out_col_wrap) begin
          out_col  <= '0;
          out_slot <= out_slot + SLOT_W'(1);
          out_row  <= out_row_wrap ? '0 : ROW_W'(out_row_inc);
        end else begin
          out_col <= COL_W'(out_col_inc);
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cmd.px[r][0] = col_a[r];
      cmd.px[r][1] = col_b[r];
      cmd.px[r][2] = new_col[r];
    end
    cmd.up        = out_row != '0;
    cmd.down      = !out_row_wrap;
    cmd.left      = out_col != '0;
    cmd.right     = !out_col_wrap;
    cmd.row_odd   = out_row[0];
    cmd.col_odd   = out_col[0];
    cmd.row_end   = out_col_wrap;
    cmd.frame_end = out_col_wrap && out_row_wrap;
  end

  assign cmd_push = emit;

endmodule

>>> hw/rtl/bbd_cmd_fifo.sv
module bbd_cmd_fifo import bbd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  win_cmd_t din,
  output logic     full,
  input  logic     pop,
  output win_cmd_t dout,
  output logic     empty
);

  win_cmd_t             entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr;
  logic [CMDQ_AW-1:0]   rd_ptr;
  logic [CMDQ_AW:0]     count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = count == (CMDQ_AW + 1)'(CMDQ_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + CMDQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + CMDQ_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (CMDQ_AW + 1)'(1);
        2'b01:   count <= count - (CMDQ_AW + 1)'(1);
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/bbd_back.sv
module bbd_back import bbd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  win_cmd_t cmd,
  input  logic     cmd_empty,
  output logic     cmd_pop,
  input  logic     pop,
  output logic     empty,
  output sample_t  red,
  output sample_t  green,
  output sample_t  blue,
  output logic     row_end,
  output logic     frame_end
);

  localparam int SUM_W      = SAMPLE_BITS + 2;
  localparam int CNT_W      = 3;
  localparam int DIV3_SHIFT = SAMPLE_BITS + 3;
  localparam int DIV3_MULT  = ((1 << DIV3_SHIFT) + 2) / 3;
  localparam int PROD_W     = SUM_W + DIV3_SHIFT;

  logic [SUM_W-1:0] hs, vs, ds;
  logic [CNT_W-1:0] hn, vn, dn;
  logic [SUM_W-1:0] num_a, num_b;
  logic [CNT_W-1:0] cnt_a, cnt_b;
  site_t            site;

  logic             s1_valid;
  site_t            s1_site;
  sample_t          s1_own;
  logic [SUM_W-1:0] s1_num_a, s1_num_b;
  logic [CNT_W-1:0] s1_cnt_a, s1_cnt_b;
  logic             s1_row_end, s1_frame_end;

  logic              out_valid;
  logic              out_adv;
  logic              s1_ready;
  logic [PROD_W-1:0] prod;
  sample_t           mean_a, mean_b;
  sample_t           red_d, green_d, blue_d;

  assign out_adv  = !out_valid || pop;
  assign s1_ready = !s1_valid || out_adv;
  assign cmd_pop  = s1_ready && !cmd_empty;
  assign empty    = !out_valid;

  // neighbor sums, masked at frame edges
  always_comb begin
    hs = (cmd.left ? SUM_W'(cmd.px[1][0]) : '0) + (cmd.right ? SUM_W'(cmd.px[1][2]) : '0);
    hn = CNT_W'(cmd.left) + CNT_W'(cmd.right);
    vs = (cmd.up ? SUM_W'(cmd.px[0][1]) : '0) + (cmd.down ? SUM_W'(cmd.px[2][1]) : '0);
    vn = CNT_W'(cmd.up) + CNT_W'(cmd.down);
    ds = ((cmd.up && cmd.left)    ? SUM_W'(cmd.px[0][0]) : '0)
       + ((cmd.up && cmd.right)   ? SUM_W'(cmd.px[0][2]) : '0)
       + ((cmd.down && cmd.left)  ? SUM_W'(cmd.px[2][0]) : '0)
       + ((cmd.down && cmd.right) ? SUM_W'(cmd.px[2][2]) : '0);
    dn = CNT_W'(cmd.up && cmd.left) + CNT_W'(cmd.up && cmd.right)
       + CNT_W'(cmd.down && cmd.left) + CNT_W'(cmd.down && cmd.right);
    site = site_t'({cmd.row_odd, cmd.col_odd});
    case (site)
      SITE_RED, SITE_BLUE: begin
        num_a = hs + vs;
        cnt_a = hn + vn;
        num_b = ds;
        cnt_b = dn;
      end
      default: begin
        num_a = hs;
        cnt_a = hn;
        num_b = vs;
        cnt_b = vn;
      end
    endcase
  end

  // divide by 1..4; divide by 3 through the reciprocal
  always_comb begin
    prod = PROD_W'(s1_num_a) * PROD_W'(DIV3_MULT);
    case (s1_cnt_a)
      3'd1:    mean_a = SAMPLE_BITS'(s1_num_a);
      3'd2:    mean_a = SAMPLE_BITS'(s1_num_a >> 1);
      3'd3:    mean_a = SAMPLE_BITS'(prod >> DIV3_SHIFT);
      3'd4:    mean_a = SAMPLE_BITS'(s1_num_a >> 2);
      default: mean_a = '0;
    endcase
    case (s1_cnt_b)
      3'd1:    mean_b = SAMPLE_BITS'(s1_num_b);
      3'd2:    mean_b = SAMPLE_BITS'(s1_num_b >> 1);
      3'd4:    mean_b = SAMPLE_BITS'(s1_num_b >> 2);
      default: mean_b = '0;
    endcase
    case (s1_site)
      SITE_GR: begin
        red_d   = mean_a;
        green_d = s1_own;
        blue_d  = mean_b;
      end
      SITE_RED: begin
        red_d   = s1_own;
        green_d = mean_a;
        blue_d  = mean_b;
      end
      SITE_BLUE: begin
        red_d   = mean_b;
        green_d = mean_a;
        blue_d  = s1_own;
      end
      default: begin
        red_d   = mean_b;
        green_d = s1_own;
        blue_d  = mean_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_site      <= site;
      s1_own       <= cmd.px[1][1];
      s1_num_a     <= num_a;
      s1_cnt_a     <= cnt_a;
      s1_num_b     <= num_b;
      s1_cnt_b     <= cnt_b;
      s1_row_end   <= cmd.row_end;
      s1_frame_end <= cmd.frame_end;
    end
    if (out_adv && s1_valid) begin
      red       <= red_d;
      green     <= green_d;
      blue      <= blue_d;
      row_end   <= s1_row_end;
      frame_end <= s1_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= !cmd_empty;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule

>>> tb/demosaic_checker.sv
module demosaic_checker import bbd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    push,
  input  logic                    full,
  input  logic                    action,
  input  logic [SAMPLE_BITS-1:0]  sample,
  input  logic                    pop,
  input  logic                    empty,
  input  logic [SAMPLE_BITS-1:0]  red,
  input  logic [SAMPLE_BITS-1:0]  green,
  input  logic [SAMPLE_BITS-1:0]  blue,
  input  logic                    row_end,
  input  logic                    frame_end,
  output int                      mismatches,
  output int                      awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sample_t red;
    sample_t green;
    sample_t blue;
    logic    row_end;
    logic    frame_end;
  } pixel_t;

  logic [CFG_BITS-1:0] width_reg;
  logic [CFG_BITS-1:0] height_reg;

  sample_t     line_mem [NUM_SLOTS][MAX_WIDTH];
  int unsigned wr_col, wr_row, wr_slot;
  int unsigned rd_col, rd_row, rd_slot;
  int unsigned backlog;

  pixel_t awaited_pixels[$];
  int     pixels_seen;

  function automatic int unsigned clamp_dim(logic [CFG_BITS-1:0] raw, int unsigned hi);
    if (raw < 2) return 2;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic int unsigned avg(int unsigned sum, int unsigned n);
    return (n != 0) ? sum / n : 0;
  endfunction

  // bilinear interpolation at the current output position, then advance it
  function automatic pixel_t next_pixel(int unsigned w, int unsigned h);
    int unsigned r, c, su, sd;
    int unsigned hs, hn, vs, vn, ds, dn;
    int unsigned rv, gv, bv;
    bit          has_up, has_down, has_left, has_right;
    sample_t     own;
    site_t       site;
    pixel_t      px;
    r = rd_row;
    c = rd_col;
    su = (rd_slot + 3) % NUM_SLOTS;
    sd = (rd_slot + 1) % NUM_SLOTS;
    has_up = r > 0;
    has_down = r + 1 < h;
    has_left = c > 0;
    has_right = c + 1 < w;
    hs = 0; hn = 0; vs = 0; vn = 0; ds = 0; dn = 0;
    own = line_mem[rd_slot][c];
    if (has_left) begin hs += line_mem[rd_slot][c-1]; hn++; end
    if (has_right) begin hs += line_mem[rd_slot][c+1]; hn++; end
    if (has_up) begin vs += line_mem[su][c]; vn++; end
    if (has_down) begin vs += line_mem[sd][c]; vn++; end
    if (has_up && has_left) begin ds += line_mem[su][c-1]; dn++; end
    if (has_up && has_right) begin ds += line_mem[su][c+1]; dn++; end
    if (has_down && has_left) begin ds += line_mem[sd][c-1]; dn++; end
    if (has_down && has_right) begin ds += line_mem[sd][c+1]; dn++; end
    site = site_t'({r[0], c[0]});
    case (site)
      SITE_GR: begin
        gv = own; bv = avg(vs, vn); rv = avg(hs, hn);
      end
      SITE_RED: begin
        rv = own; bv = avg(ds, dn); gv = avg(hs + vs, hn + vn);
      end
      SITE_BLUE: begin
        bv = own; rv = avg(ds, dn); gv = avg(hs + vs, hn + vn);
      end
      default: begin
        gv = own; rv = avg(vs, vn); bv = avg(hs, hn);
      end
    endcase
    px.red = sample_t'(rv);
    px.green = sample_t'(gv);
    px.blue = sample_t'(bv);
    px.row_end = (c + 1 >= w);
    px.frame_end = (c + 1 >= w) && (r + 1 >= h);
    rd_col++;
    if (rd_col >= w) begin
      rd_col = 0;
      rd_slot = (rd_slot + 1) % NUM_SLOTS;
      rd_row++;
      if (rd_row >= h) rd_row = 0;
    end
    if (backlog > 0) backlog--;
    return px;
  endfunction

  // returns 1 when the word yields a pixel
  function automatic bit take_word(logic act, sample_t value, output pixel_t px);
    int unsigned w, h;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    px = '0;
    if (act == ACT_FLUSH) begin
      if (wr_row == 0 && wr_col == 0 && backlog > 0) begin
        px = next_pixel(w, h);
        return 1;
      end
      return 0;
    end
    line_mem[wr_slot][wr_col] = value;
    wr_col++;
    if (wr_col >= w) begin
      wr_col = 0;
      wr_slot = (wr_slot + 1) % NUM_SLOTS;
      wr_row++;
      if (wr_row >= h) wr_row = 0;
    end
    backlog++;
    if (backlog > w + 1) begin
      px = next_pixel(w, h);
      return 1;
    end
    return 0;
  endfunction

  task automatic flag(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pixel_t want, got;
    if (rst) begin
      width_reg = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      wr_col = 0; wr_row = 0; wr_slot = 0;
      rd_col = 0; rd_row = 0; rd_slot = 0;
      backlog = 0;
      pixels_seen = 0;
      mismatches = 0;
      awaited_pixels.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_reg = cfg_data;
          CFG_FRAME_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        got = '{red, green, blue, row_end, frame_end};
        if (awaited_pixels.size() == 0) begin
          flag($sformatf("word %0d arrived with nothing expected", pixels_seen));
        end else begin
          want = awaited_pixels.pop_front();
          if (got.red !== want.red)
            flag($sformatf("word %0d red %0d, want %0d", pixels_seen, got.red, want.red));
          if (got.green !== want.green)
            flag($sformatf("word %0d green %0d, want %0d", pixels_seen, got.green,
                           want.green));
          if (got.blue !== want.blue)
            flag($sformatf("word %0d blue %0d, want %0d", pixels_seen, got.blue, want.blue));
          if (got.row_end !== want.row_end)
            flag($sformatf("word %0d row_end %b, want %b", pixels_seen, got.row_end,
                           want.row_end));
          if (got.frame_end !== want.frame_end)
            flag($sformatf("word %0d frame_end %b, want %b", pixels_seen, got.frame_end,
                           want.frame_end));
        end
        pixels_seen++;
      end
      if (push && !full) begin
        if (take_word(action, sample, want)) awaited_pixels.push_back(want);
      end
    end
    awaited <= awaited_pixels.size();
  end

endmodule

>>> tb/bayer_bilinear_demosaic_test.sv
module bayer_bilinear_demosaic_test import bbd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1700;

  logic                    clk;
  logic                    rst;
  logic                    cfg_write;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;
  logic                    push;
  logic                    action;
  logic [SAMPLE_BITS-1:0]  sample;
  logic                    full;
  logic                    pop;
  logic                    empty;
  logic [SAMPLE_BITS-1:0]  red;
  logic [SAMPLE_BITS-1:0]  green;
  logic [SAMPLE_BITS-1:0]  blue;
  logic                    row_end;
  logic                    frame_end;

  int mismatches;
  int awaited;

  int          burst_left;
  bit          calm;
  int unsigned cur_w, cur_h;
  int          random_sent;

  bayer_bilinear_demosaic dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .action(action), .sample(sample), .full(full),
    .pop(pop), .empty(empty),
    .red(red), .green(green), .blue(blue), .row_end(row_end), .frame_end(frame_end)
  );

  demosaic_checker chk (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .action(action), .sample(sample),
    .pop(pop), .empty(empty),
    .red(red), .green(green), .blue(blue), .row_end(row_end), .frame_end(frame_end),
    .mismatches(mismatches), .awaited(awaited)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver stalls
  initial begin
    int          mode, tick;
    logic [31:0] pattern;
    pop = 1'b0;
    tick = 0;
    mode = 0;
    pattern = '0;
    forever begin
      @(posedge clk);
      if (tick == 0) begin
        mode = $urandom_range(0, 3);
        tick = $urandom_range(20, 200);
        pattern = $urandom;
      end
      tick--;
      case (mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= pattern[tick % 32];
        default: pop <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned clamp_dim(logic [CFG_BITS-1:0] raw, int unsigned hi);
    if (raw < 2) return 2;
    if (raw > hi) return hi;
    return raw;
  endfunction

  task automatic send_word(logic act, sample_t value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    action <= act;
    sample <= value;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(logic [CFG_BITS-1:0] raw_w, logic [CFG_BITS-1:0] raw_h);
    wait_idle();
    cfg_write <= 1'b1;
    if ($urandom_range(0, 1)) begin
      cfg_index <= CFG_FRAME_WIDTH;
      cfg_data <= raw_w;
      @(posedge clk);
      cfg_index <= CFG_FRAME_HEIGHT;
      cfg_data <= raw_h;
    end else begin
      cfg_index <= CFG_FRAME_HEIGHT;
      cfg_data <= raw_h;
      @(posedge clk);
      cfg_index <= CFG_FRAME_WIDTH;
      cfg_data <= raw_w;
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_w = clamp_dim(raw_w, MAX_WIDTH);
    cur_h = clamp_dim(raw_h, MAX_HEIGHT);
    calm = ($urandom_range(0, 3) == 0);
  endtask

  // stray flushes inside a frame must be ignored
  task automatic send_frame(bit noisy);
    for (int i = 0; i < cur_w * cur_h; i++) begin
      if (noisy && i > 0 && $urandom_range(0, 15) == 0)
        send_word(ACT_FLUSH, sample_t'($urandom));
      send_word(ACT_SAMPLE, pick_sample());
    end
  endtask

  task automatic drain_frame();
    repeat (cur_w + 1 + $urandom_range(0, 2)) send_word(ACT_FLUSH, sample_t'($urandom));
  endtask

  initial begin
    int          frames;
    logic [CFG_BITS-1:0] raw_w, raw_h;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    push = 1'b0;
    action = ACT_SAMPLE;
    sample = '0;
    burst_left = 0;
    calm = 1'b1;
    cur_w = 640;
    cur_h = 480;
    random_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // flush with nothing pending
    send_word(ACT_FLUSH, '1);

    // smallest frame via low clamps, stray flush mid-frame
    set_size(CFG_BITS'(0), CFG_BITS'(1));
    send_word(ACT_SAMPLE, '1);
    send_word(ACT_FLUSH, '0);
    send_word(ACT_SAMPLE, '0);
    send_word(ACT_SAMPLE, '0);
    send_word(ACT_SAMPLE, '1);
    drain_frame();

    set_size(CFG_BITS'(3), CFG_BITS'(3));
    send_word(ACT_SAMPLE, '1);
    send_word(ACT_SAMPLE, '0);
    send_word(ACT_SAMPLE, '1);
    send_word(ACT_SAMPLE, '1);
    send_word(ACT_SAMPLE, 12'd1);
    send_word(ACT_SAMPLE, '1);
    send_word(ACT_SAMPLE, 12'd2);
    send_word(ACT_SAMPLE, '1);
    send_word(ACT_SAMPLE, 12'hffe);
    drain_frame();

    while (random_sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0: raw_w = CFG_BITS'($urandom_range(0, 2));
        1: raw_w = CFG_BITS'($urandom_range(13, 40));
        default: raw_w = CFG_BITS'($urandom_range(3, 10));
      endcase
      raw_h = ($urandom_range(0, 5) == 0) ? CFG_BITS'($urandom_range(0, 2))
                                          : CFG_BITS'($urandom_range(3, 7));
      set_size(raw_w, raw_h);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        send_frame(1'b1);
        random_sent += cur_w * cur_h;
        // partial drain between back-to-back frames
        if (f + 1 < frames && $urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, cur_w + 1)) send_word(ACT_FLUSH, sample_t'($urandom));
        end
      end
      drain_frame();
      random_sent += cur_w + 1;
    end

    push <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
